/* rtl/llrb_pkg.sv */
package llrb_pkg;

   // Ring geometry
   localparam int RING_BYTES    = 8192;
   localparam int PTR_W         = $clog2(RING_BYTES);
   localparam int HELD_W        = $clog2(RING_BYTES + 1);

   // Pop limit: at most MAX_POP_LIMIT - 1 text bytes per line
   localparam int MAX_POP_LIMIT = 64;
   localparam int LIMIT_W       = 7;
   localparam int TEXT_W        = $clog2(MAX_POP_LIMIT);

   localparam int BYTE_W        = 8;
   localparam int DROP_W        = 32;

   // Opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;

   // Classified command as it sits in the queue
   typedef struct packed {
      logic              is_pop;
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_message;
      logic [TEXT_W-1:0] text_max;
   } cmd_type;

   // Number of text bytes a pop may emit for a given caller limit
   function automatic logic [TEXT_W-1:0] text_budget(input logic [LIMIT_W-1:0] limit);
      logic [TEXT_W-1:0] budget;
      if (limit > LIMIT_W'(MAX_POP_LIMIT)) begin
         budget = TEXT_W'(MAX_POP_LIMIT - 1);
      end else if (limit == '0) begin
         budget = '0;
      end else begin
         budget = TEXT_W'(limit - LIMIT_W'(1));
      end
      return budget;
   endfunction

   // Ring pointer advance with wrap
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(RING_BYTES - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

endpackage

/* rtl/llrb_front.sv */
module llrb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [llrb_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          req_end_of_message,
   input  logic [llrb_pkg::LIMIT_W-1:0]  req_pop_limit,
   output logic                          cmd_valid,
   output llrb_pkg::cmd_type             cmd,
   input  logic                          cmd_take
);

   localparam int DEPTH = 2;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   llrb_pkg::cmd_type       entry_ff [DEPTH];
   llrb_pkg::cmd_type       new_cmd;
   logic [IDX_W-1:0]        wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    push_q;
   logic                    pop_q;

   // Classify the incoming item
   always_comb begin
      new_cmd.is_pop         = (req_opcode == llrb_pkg::OP_POP);
      new_cmd.data_byte      = req_data_byte;
      new_cmd.end_of_message = req_end_of_message;
      new_cmd.text_max       = llrb_pkg::text_budget(req_pop_limit);
   end

   assign req_ready = (count_ff != CNT_W'(DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_idx_ff];
   assign push_q    = req_valid && req_ready;
   assign pop_q     = cmd_take && cmd_valid;

   // Queue pointers
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (push_q) begin
         wr_idx_in = (wr_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_ff + IDX_W'(1);
      end
      if (pop_q) begin
         rd_idx_in = (rd_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_ff + IDX_W'(1);
      end
      if (push_q && !pop_q) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_q && !push_q) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push_q) begin
         entry_ff[wr_idx_ff] <= new_cmd;
      end
   end

endmodule

/* rtl/llrb_back.sv */
module llrb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  llrb_pkg::cmd_type             cmd,
   output logic                          cmd_take,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [llrb_pkg::BYTE_W-1:0]   rsp_text_byte,
   output logic                          rsp_last,
   output logic                          rsp_got_text,
   output logic [llrb_pkg::DROP_W-1:0]   rsp_dropped_bytes,
   output logic [llrb_pkg::HELD_W-1:0]   held_level
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_PUSH_NL   = 3'd1;
   localparam logic [2:0] ST_POP_READ  = 3'd2;
   localparam logic [2:0] ST_POP_CHECK = 3'd3;
   localparam logic [2:0] ST_POP_CLOSE = 3'd4;

   logic [llrb_pkg::BYTE_W-1:0] ring_mem [llrb_pkg::RING_BYTES];
   logic [llrb_pkg::BYTE_W-1:0] rd_data_ff;

   logic [2:0]                  state_ff, state_in;
   logic [llrb_pkg::PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [llrb_pkg::PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [llrb_pkg::HELD_W-1:0] held_ff, held_in;
   logic [llrb_pkg::DROP_W-1:0] drop_ff, drop_in;
   logic [llrb_pkg::TEXT_W-1:0] written_ff, written_in;
   logic [llrb_pkg::TEXT_W-1:0] text_max_ff, text_max_in;

   logic                        do_store;
   logic [llrb_pkg::BYTE_W-1:0] store_byte;
   logic                        out_free;
   logic                        out_load;
   logic [llrb_pkg::BYTE_W-1:0] out_byte;
   logic                        out_last;
   logic                        out_got;

   logic                        rsp_valid_ff;
   logic [llrb_pkg::BYTE_W-1:0] text_byte_ff;
   logic                        last_ff;
   logic                        got_text_ff;
   logic [llrb_pkg::DROP_W-1:0] dropped_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: pushes store one or two bytes, pops walk the ring a byte at a time
   always_comb begin
      state_in    = state_ff;
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      held_in     = held_ff;
      drop_in     = drop_ff;
      written_in  = written_ff;
      text_max_in = text_max_ff;
      cmd_take    = 1'b0;
      do_store    = 1'b0;
      store_byte  = cmd.data_byte;
      out_load    = 1'b0;
      out_byte    = '0;
      out_last    = 1'b0;
      out_got     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               if (cmd.is_pop) begin
                  written_in  = '0;
                  text_max_in = cmd.text_max;
                  state_in    = ST_POP_READ;
               end else begin
                  do_store   = 1'b1;
                  store_byte = cmd.data_byte;
                  if (cmd.end_of_message) begin
                     state_in = ST_PUSH_NL;
                  end
               end
            end
         end
         ST_PUSH_NL: begin
            do_store   = 1'b1;
            store_byte = llrb_pkg::NEWLINE_CODE;
            state_in   = ST_IDLE;
         end
         ST_POP_READ: begin
            // memory read of rd_ptr lands in rd_data_ff next cycle
            if (held_ff == '0 || written_ff == text_max_ff) begin
               state_in = ST_POP_CLOSE;
            end else begin
               state_in = ST_POP_CHECK;
            end
         end
         ST_POP_CHECK: begin
            if (rd_data_ff == llrb_pkg::NEWLINE_CODE) begin
               rd_ptr_in = llrb_pkg::ptr_next(rd_ptr_ff);
               held_in   = held_ff - llrb_pkg::HELD_W'(1);
               state_in  = ST_POP_CLOSE;
            end else if (out_free) begin
               rd_ptr_in  = llrb_pkg::ptr_next(rd_ptr_ff);
               held_in    = held_ff - llrb_pkg::HELD_W'(1);
               written_in = written_ff + llrb_pkg::TEXT_W'(1);
               out_load   = 1'b1;
               out_byte   = rd_data_ff;
               state_in   = ST_POP_READ;
            end
         end
         ST_POP_CLOSE: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               out_got  = (written_ff != '0);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Store one byte, overwriting the oldest when full
      if (do_store) begin
         wr_ptr_in = llrb_pkg::ptr_next(wr_ptr_ff);
         if (held_ff == llrb_pkg::HELD_W'(llrb_pkg::RING_BYTES)) begin
            rd_ptr_in = llrb_pkg::ptr_next(rd_ptr_ff);
            drop_in   = drop_ff + llrb_pkg::DROP_W'(1);
         end else begin
            held_in = held_ff + llrb_pkg::HELD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         held_ff     <= '0;
         drop_ff     <= '0;
         written_ff  <= '0;
         text_max_ff <= '0;
      end else begin
         state_ff    <= state_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         held_ff     <= held_in;
         drop_ff     <= drop_in;
         written_ff  <= written_in;
         text_max_ff <= text_max_in;
      end
   end

   // Ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_store) begin
         ring_mem[wr_ptr_ff] <= store_byte;
      end
      rd_data_ff <= ring_mem[rd_ptr_ff];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         text_byte_ff <= out_byte;
         last_ff      <= out_last;
         got_text_ff  <= out_got;
         dropped_ff   <= drop_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_text_byte     = text_byte_ff;
   assign rsp_last          = last_ff;
   assign rsp_got_text      = got_text_ff;
   assign rsp_dropped_bytes = dropped_ff;
   assign held_level        = held_ff;

endmodule

/* rtl/line_log_ring_buffer_unit.sv */
// Log text ring of 8192 bytes that overwrites its oldest byte when full and
// counts every byte lost that way. A push item stores its byte, followed by
// a newline when end_of_message is set; it gives no result. A pop item
// reads the ring from the oldest end, one text byte at a time (registered
// memory read, then check and emit), stopping at a newline (consumed, not
// emitted), at pop_limit - 1 bytes (limit capped at 64), or at an empty ring,
// then delivers one closing item with last set. Every result carries the
// drop count. A two-entry command queue sits between the input side and the
// executing sequencer, and a result register lets the next item be taken
// while a result waits. Ring contents are not cleared at reset; only bytes
// actually stored are ever read.
module line_log_ring_buffer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [llrb_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          req_end_of_message,
   input  logic [llrb_pkg::LIMIT_W-1:0]  req_pop_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [llrb_pkg::BYTE_W-1:0]   rsp_text_byte,
   output logic                          rsp_last,
   output logic                          rsp_got_text,
   output logic [llrb_pkg::DROP_W-1:0]   rsp_dropped_bytes
);

   logic                        cmd_valid;
   llrb_pkg::cmd_type           cmd;
   logic                        cmd_take;
   logic [llrb_pkg::HELD_W-1:0] held_level;

   llrb_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .req_pop_limit      (req_pop_limit),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_take           (cmd_take)
   );

   llrb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_take          (cmd_take),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_text_byte     (rsp_text_byte),
      .rsp_last          (rsp_last),
      .rsp_got_text      (rsp_got_text),
      .rsp_dropped_bytes (rsp_dropped_bytes),
      .held_level        (held_level)
   );

   // Fill level never passes the ring size
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_level <= llrb_pkg::HELD_W'(llrb_pkg::RING_BYTES))
      else $error("ring fill level above capacity");

   // Fill level moves by at most one byte per cycle
   a_held_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (held_level == $past(held_level) ||
                         held_level == $past(held_level) + llrb_pkg::HELD_W'(1) ||
                         held_level == $past(held_level) - llrb_pkg::HELD_W'(1)))
      else $error("ring fill level jumped");

   // Input stalls only when the command queue holds work
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |-> cmd_valid)
      else $error("input stalled with empty command queue");

endmodule
